>>> rtl/core/axis_angle_vector_rotate_defines.svh
// Assertion macros for the axis angle vector rotate block
`ifndef AXIS_ANGLE_VECTOR_ROTATE_DEFINES_SVH
`define AXIS_ANGLE_VECTOR_ROTATE_DEFINES_SVH

// Implication checked at every rising edge, skipped in reset
`define AAVR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, skipped in reset
`define AAVR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/aavr_pkg.sv
// Package: constants and tables for the axis angle vector rotate block
package aavr_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int TRIG_ITER_DEF = 16;
    localparam int ANG_FRAC      = 24;
    localparam int TRIG_FRAC     = 30;
    localparam int TABLE_LEN     = 24;
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

    // atan(2^-i) in Q24 degrees
    function automatic logic signed [31:0] atan_q24(input int i);
        logic signed [31:0] t;
        case (i)
            0: t = 32'sd754974720;   1: t = 32'sd445687602;
            2: t = 32'sd235489088;   3: t = 32'sd119537938;
            4: t = 32'sd60000934;    5: t = 32'sd30029717;
            6: t = 32'sd15018523;    7: t = 32'sd7509720;
            8: t = 32'sd3754917;     9: t = 32'sd1877466;
            10: t = 32'sd938734;     11: t = 32'sd469367;
            12: t = 32'sd234684;     13: t = 32'sd117342;
            14: t = 32'sd58671;      15: t = 32'sd29335;
            16: t = 32'sd14668;      17: t = 32'sd7334;
            18: t = 32'sd3667;       19: t = 32'sd1833;
            20: t = 32'sd917;        21: t = 32'sd458;
            22: t = 32'sd229;        23: t = 32'sd115;
            default: t = 32'sd0;
        endcase
        return t;
    endfunction
endpackage

>>> rtl/core/aavr_cordic.sv
// Pipelined degree-domain CORDIC: sine and cosine, one stage per iteration
module aavr_cordic #(
    parameter int FRAC_BITS = aavr_pkg::FRAC_BITS_DEF,
    parameter int N_ITER    = aavr_pkg::TRIG_ITER_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [33:0]           i_z,
    input  logic                         i_neg,
    output logic signed [FRAC_BITS+2:0]  o_cos,
    output logic signed [FRAC_BITS+2:0]  o_sin
);
    localparam int RSH = aavr_pkg::TRIG_FRAC - FRAC_BITS;

    logic signed [32:0] r_x [N_ITER+1];
    logic signed [32:0] r_y [N_ITER+1];
    logic signed [33:0] r_z [N_ITER+1];
    logic               r_ng[N_ITER+1];
    logic signed [FRAC_BITS+2:0] r_c, r_s;
    logic signed [32:0] fx, fy;

    // load stage, then one register stage per iteration
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= 33'(aavr_pkg::GAIN_Q30);
            r_y[0]  <= '0;
            r_z[0]  <= i_z;
            r_ng[0] <= i_neg;
            for (int g = 0; g < N_ITER; g++) begin
                r_ng[g+1] <= r_ng[g];
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - 34'(aavr_pkg::atan_q24(g));
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + 34'(aavr_pkg::atan_q24(g));
                end
            end
        end
    end

    assign fx = r_ng[N_ITER] ? -r_x[N_ITER] : r_x[N_ITER];
    assign fy = r_ng[N_ITER] ? -r_y[N_ITER] : r_y[N_ITER];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c <= (FRAC_BITS+3)'((fx + (33'sd1 <<< (RSH-1))) >>> RSH);
            r_s <= (FRAC_BITS+3)'((fy + (33'sd1 <<< (RSH-1))) >>> RSH);
        end
    end
    assign o_cos = r_c;
    assign o_sin = r_s;
endmodule

>>> rtl/core/axis_angle_vector_rotate.sv
// Top level: streaming 3D vector rotation about a unit axis (Rodrigues)
//
// Slave channel carries one rotation request per transaction: vector,
// unit axis and angle in degrees, all signed fixed point with FRAC_BITS
// fraction bits. Master channel returns the rotated vector and a flag that
// is set when any component was clipped to the signed 32-bit range.
// Every request gives exactly one result, in order.
// Throughput: one transaction per cycle while the output is not stalled. The
// pipeline is the angle prep stage, the pipelined CORDIC (load, one stage per
// iteration for min(TRIG_ITERATIONS, 24) iterations, round), then the multiply and round stages.
// The whole pipeline advances on one enable; when the receiver stalls
// with a result held at the output, the pipeline freezes, and s_axis_tready
// falls only when the output stage is full and blocked, so nothing is lost
// or repeated. Reset clears the valid bits only; data registers hold junk.
// Reset is synchronous, active low.
`include "axis_angle_vector_rotate_defines.svh"
module axis_angle_vector_rotate #(
    parameter int FRAC_BITS       = aavr_pkg::FRAC_BITS_DEF,
    parameter int TRIG_ITERATIONS = aavr_pkg::TRIG_ITER_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // vec_x[31:0] vec_y[63:32] vec_z[95:64] axis_x[113:96] axis_y[131:114]
    // axis_z[149:132] angle_deg[175:150]
    input  logic [175:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x[31:0] out_y[63:32] out_z[95:64] saturated[96] zero pad[103:97]
    output logic [103:0] m_axis_tdata
);
    localparam int NIT  = (TRIG_ITERATIONS > aavr_pkg::TABLE_LEN) ?
                          aavr_pkg::TABLE_LEN : TRIG_ITERATIONS;
    localparam int CL   = NIT + 3;      // prep + load + iterations + round
    localparam int LAT  = CL + 6;       // total stages incl. output
    localparam int F    = FRAC_BITS;
    localparam int CW   = F + 3;
    localparam int AS   = aavr_pkg::ANG_FRAC - F;
    localparam longint FULL = 64'sd360 <<< aavr_pkg::ANG_FRAC;
    localparam longint QTR  = 64'sd90 <<< aavr_pkg::ANG_FRAC;

    logic en;
    logic [LAT-1:0] r_vld;

    // output register is last valid bit
    assign en = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
    end

    // ---- angle reduction (one stage, feeds CORDIC) ----
    logic signed [25:0] ang_in;
    logic signed [40:0] a24;
    logic signed [40:0] n_am;
    logic signed [33:0] n_z;
    logic n_neg;
    assign ang_in = s_axis_tdata[175:150];
    assign a24 = 41'(ang_in) <<< AS;
    always_comb begin
        // |a24| stays below two full turns: pick the wrap in parallel
        if (a24 >= 41'(FULL)) n_am = a24 - 41'(FULL);
        else if (a24 >= 0) n_am = a24;
        else if (a24 > -41'(FULL)) n_am = a24 + 41'(FULL);
        else n_am = a24 + 41'(2*FULL);
        n_neg = 1'b0;
        if (n_am > 41'(3*QTR)) n_z = 34'(n_am - 41'(FULL));
        else if (n_am > 41'(QTR)) begin
            n_z = 34'(n_am - 41'(2*QTR));
            n_neg = 1'b1;
        end else n_z = 34'(n_am);
    end

    logic signed [33:0] r_z0;
    logic r_ng0;
    always_ff @(posedge i_clk) if (en) begin
        r_z0 <= n_z;
        r_ng0 <= n_neg;
    end

    logic signed [CW-1:0] cs_c, cs_s;
    aavr_cordic #(.FRAC_BITS(F), .N_ITER(NIT)) u_cordic (
        .i_clk(i_clk), .i_en(en), .i_z(r_z0), .i_neg(r_ng0),
        .o_cos(cs_c), .o_sin(cs_s));
    // cordic result ready after 1 + 1 + NIT + 1 = CL stages from input

    // ---- vector/axis delay and dot/cross products in parallel ----
    logic signed [31:0] iv [3];
    logic signed [17:0] ia [3];
    assign iv[0] = s_axis_tdata[31:0];
    assign iv[1] = s_axis_tdata[63:32];
    assign iv[2] = s_axis_tdata[95:64];
    assign ia[0] = s_axis_tdata[113:96];
    assign ia[1] = s_axis_tdata[131:114];
    assign ia[2] = s_axis_tdata[149:132];

    // stage P1: nine products axis_i*v_j
    logic signed [49:0] r_pr [3][3];
    logic signed [31:0] r_v1 [3];
    logic signed [17:0] r_a1 [3];
    always_ff @(posedge i_clk) if (en) begin
        for (int i = 0; i < 3; i++) begin
            r_v1[i] <= iv[i];
            r_a1[i] <= ia[i];
            for (int j = 0; j < 3; j++) r_pr[i][j] <= 50'(ia[i]) * 50'(iv[j]);
        end
    end
    // stage P2: dot and cross, rounded
    logic signed [52:0] r_dot;
    logic signed [51:0] r_cr [3];
    logic signed [31:0] r_v2 [3];
    logic signed [17:0] r_a2 [3];
    logic signed [52:0] dsum;
    logic signed [51:0] cx [3];
    localparam longint HALF = 64'sd1 <<< (F-1);
    always_comb begin
        dsum = 53'(r_pr[0][0]) + 53'(r_pr[1][1]) + 53'(r_pr[2][2]);
        cx[0] = 52'(r_pr[1][2]) - 52'(r_pr[2][1]);
        cx[1] = 52'(r_pr[2][0]) - 52'(r_pr[0][2]);
        cx[2] = 52'(r_pr[0][1]) - 52'(r_pr[1][0]);
    end
    always_ff @(posedge i_clk) if (en) begin
        r_dot <= (dsum + 53'(HALF)) >>> F;
        for (int i = 0; i < 3; i++) begin
            r_cr[i] <= (cx[i] + 52'(HALF)) >>> F;
            r_v2[i] <= r_v1[i];
            r_a2[i] <= r_a1[i];
        end
    end
    // delay line to meet the CORDIC output (CL - 2 more stages)
    localparam int DL = CL - 2;
    logic signed [52:0] r_dd [DL];
    logic signed [51:0] r_cd [DL][3];
    logic signed [31:0] r_vd [DL][3];
    logic signed [17:0] r_ad [DL][3];
    always_ff @(posedge i_clk) if (en) begin
        r_dd[0] <= r_dot;
        r_cd[0] <= r_cr;
        r_vd[0] <= r_v2;
        r_ad[0] <= r_a2;
        for (int g = 1; g < DL; g++) begin
            r_dd[g] <= r_dd[g-1];
            r_cd[g] <= r_cd[g-1];
            r_vd[g] <= r_vd[g-1];
            r_ad[g] <= r_ad[g-1];
        end
    end

    // stage M1: 1-c, products v*c, cr*s, dot*(1-c)
    logic signed [CW:0] omc;
    assign omc = (CW+1)'(64'sd1 <<< F) - (CW+1)'(cs_c);
    logic signed [53+CW:0] r_pd;
    logic signed [31+CW:0] r_vc [3];
    logic signed [51+CW:0] r_cs [3];
    logic signed [17:0] r_a3 [3];
    always_ff @(posedge i_clk) if (en) begin
        r_pd <= (54+CW)'(r_dd[DL-1]) * (54+CW)'(omc);
        for (int i = 0; i < 3; i++) begin
            r_vc[i] <= (32+CW)'(r_vd[DL-1][i]) * (32+CW)'(cs_c);
            r_cs[i] <= (52+CW)'(r_cd[DL-1][i]) * (52+CW)'(cs_s);
            r_a3[i] <= r_ad[DL-1][i];
        end
    end
    // stage M2: round p
    logic signed [53+CW:0] r_p;
    logic signed [31+CW:0] r_vc2 [3];
    logic signed [51+CW:0] r_cs2 [3];
    logic signed [17:0] r_a4 [3];
    always_ff @(posedge i_clk) if (en) begin
        r_p <= (r_pd + (54+CW)'(HALF)) >>> F;
        r_vc2 <= r_vc; r_cs2 <= r_cs; r_a4 <= r_a3;
    end
    // stage M3: axis*p
    localparam int AW = 72 + CW + 18;
    logic signed [AW-1:0] r_ap [3];
    logic signed [31+CW:0] r_vc3 [3];
    logic signed [51+CW:0] r_cs3 [3];
    always_ff @(posedge i_clk) if (en) begin
        for (int i = 0; i < 3; i++) r_ap[i] <= AW'(r_a4[i]) * AW'(r_p);
        r_vc3 <= r_vc2; r_cs3 <= r_cs2;
    end
    // stage S1: accumulate
    logic signed [AW-1:0] r_acc [3];
    always_ff @(posedge i_clk) if (en) begin
        for (int i = 0; i < 3; i++)
            r_acc[i] <= r_ap[i] + AW'(r_vc3[i]) + AW'(r_cs3[i]);
    end
    // stage S2: round
    logic signed [AW-1:0] r_rd [3];
    always_ff @(posedge i_clk) if (en) begin
        for (int i = 0; i < 3; i++) r_rd[i] <= (r_acc[i] + AW'(HALF)) >>> F;
    end
    // stage S3: clip into output register
    logic signed [31:0] n_o [3];
    logic n_sat;
    always_comb begin
        n_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (r_rd[i] > AW'(64'sd2147483647)) begin
                n_o[i] = 32'sh7fffffff; n_sat = 1'b1;
            end else if (r_rd[i] < -AW'(64'sd2147483648)) begin
                n_o[i] = 32'sh80000000; n_sat = 1'b1;
            end else n_o[i] = 32'(r_rd[i]);
        end
    end
    logic [31:0] r_o [3];
    logic r_sat;
    always_ff @(posedge i_clk) if (en) begin
        for (int i = 0; i < 3; i++) r_o[i] <= n_o[i];
        r_sat <= n_sat;
    end
    assign m_axis_tdata = {7'd0, r_sat, r_o[2], r_o[1], r_o[0]};

    `AAVR_ASSERT_IMP(a_stall_ready, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        !s_axis_tready, "ready high while output blocked")
    `AAVR_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `AAVR_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[103:97] == 7'd0, "padding not zero")
endmodule

>>> bench/testbench.sv
// Self-checking bench for the streaming axis-angle vector rotation block
module testbench;
    localparam int FB    = aavr_pkg::FRAC_BITS_DEF;
    localparam int ITERS = aavr_pkg::TRIG_ITER_DEF;
    localparam int LATENCY = ITERS + 9;
    localparam logic signed [25:0] ANGLE_MAX = 26'sd23592960;  // +360 degrees
    localparam logic signed [17:0] UNIT      = 18'sd65536;

    typedef struct packed {
        logic        sat;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } t_rotated;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // vec_x vec_y vec_z axis_x axis_y axis_z angle_deg, lowest first
    logic [175:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // out_x out_y out_z saturated, zero pad, lowest first
    logic [103:0] m_axis_tdata;

    t_rotated expected_rotations[$];
    int       errors = 0;
    int       send_idle_pct = 38;
    int       recv_idle_pct = 38;

    axis_angle_vector_rotate u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint round_shift(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip32(longint v, ref logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Degree-domain CORDIC, folded into (-90,90] before the iterations
    function automatic void degree_sincos(input logic signed [25:0] ang,
                                          output longint c, output longint s);
        longint full, quarter, a, x, y, z, nx;
        bit     flip;
        int     n;
        full = longint'(360) <<< aavr_pkg::ANG_FRAC;
        quarter = longint'(90) <<< aavr_pkg::ANG_FRAC;
        a = longint'(ang) * (longint'(1) <<< (aavr_pkg::ANG_FRAC - FB));
        a = a % full;
        if (a < 0) a += full;
        flip = 1'b0;
        if (a > 3 * quarter) begin
            z = a - full;
        end else if (a > quarter) begin
            z = a - 2 * quarter;
            flip = 1'b1;
        end else begin
            z = a;
        end
        n = (ITERS > aavr_pkg::TABLE_LEN) ? aavr_pkg::TABLE_LEN : ITERS;
        x = longint'(aavr_pkg::GAIN_Q30);
        y = 0;
        for (int i = 0; i < n; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= longint'(aavr_pkg::atan_q24(i));
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += longint'(aavr_pkg::atan_q24(i));
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = round_shift(x, aavr_pkg::TRIG_FRAC - FB);
        s = round_shift(y, aavr_pkg::TRIG_FRAC - FB);
    endfunction

    // Rodrigues: v*c + axis*(axis.v)*(1-c) + (axis x v)*s
    function automatic t_rotated rodrigues(logic [175:0] req);
        longint   v[3], ax[3], cr[3], c, s, dot, p, acc;
        logic     sat;
        t_rotated r;
        sat = 1'b0;
        for (int k = 0; k < 3; k++) begin
            v[k] = longint'($signed(req[32*k +: 32]));
            ax[k] = longint'($signed(req[96 + 18*k +: 18]));
        end
        degree_sincos(req[175:150], c, s);
        dot = round_shift(ax[0] * v[0] + ax[1] * v[1] + ax[2] * v[2], FB);
        p = round_shift(dot * ((longint'(1) <<< FB) - c), FB);
        cr[0] = round_shift(ax[1] * v[2] - ax[2] * v[1], FB);
        cr[1] = round_shift(ax[2] * v[0] - ax[0] * v[2], FB);
        cr[2] = round_shift(ax[0] * v[1] - ax[1] * v[0], FB);
        for (int k = 0; k < 3; k++) begin
            acc = clip32(round_shift(v[k] * c + ax[k] * p + cr[k] * s, FB), sat);
            case (k)
                0: r.x = acc[31:0];
                1: r.y = acc[31:0];
                default: r.z = acc[31:0];
            endcase
        end
        r.sat = sat;
        return r;
    endfunction

    // One request transaction; random gap before it, prediction on acceptance
    task automatic send_rotation(input logic signed [31:0] vx, vy, vz,
                                 input logic signed [17:0] ax, ay, az,
                                 input logic signed [25:0] ang);
        logic [175:0] req;
        req = {ang, az, ay, ax, vz, vy, vx};
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= req;
        forever begin
            @(negedge i_clk);
            if (s_axis_tready) begin
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
        expected_rotations.push_back(rodrigues(req));
    endtask

    function automatic logic signed [31:0] random_component();
        return $signed($urandom) >>> $urandom_range(0, 24);
    endfunction

    function automatic logic signed [17:0] random_axis();
        return 18'($signed($urandom_range(0, 131072)) - 65536);
    endfunction

    function automatic logic signed [25:0] random_angle();
        return 26'($signed($urandom_range(0, 47185920)) - 23592960);
    endfunction

    // Output side: accepted when tvalid and tready both high at the next edge
    always @(posedge i_clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(negedge i_clk) begin
        t_rotated want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_rotations.size() == 0) begin
                $error("result with nothing outstanding: %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_rotations.pop_front();
                if (m_axis_tdata[31:0] !== want.x) begin
                    $error("out_x expected %h actual %h", want.x, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[63:32] !== want.y) begin
                    $error("out_y expected %h actual %h", want.y, m_axis_tdata[63:32]);
                    errors++;
                end
                if (m_axis_tdata[95:64] !== want.z) begin
                    $error("out_z expected %h actual %h", want.z, m_axis_tdata[95:64]);
                    errors++;
                end
                if (m_axis_tdata[96] !== want.sat) begin
                    $error("saturated expected %b actual %b", want.sat, m_axis_tdata[96]);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        logic signed [25:0] corners[10];
        corners = '{26'sd0, 26'sd5898240, 26'sd11796480, 26'sd17694720, ANGLE_MAX,
                    -ANGLE_MAX, 26'sd2949120, -26'sd5898240, 26'sd33554431, 26'sd1};
        // exact quadrant edges and the full turn about the z axis
        foreach (corners[i])
            send_rotation(32'sd65536, 32'sd131072, -32'sd196608, 18'sd0, 18'sd0, UNIT,
                          corners[i]);
        send_rotation(32'sd0, 32'sd0, 32'sd0, UNIT, 18'sd0, 18'sd0, 26'sd5898240);
        send_rotation(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, -UNIT, 18'sd0, 18'sd0,
                      26'sd2949120);
        send_rotation(32'h80000000, 32'h80000000, 32'h80000000, 18'sd0, UNIT, 18'sd0,
                      -26'sd2949120);
        // non-unit axis, used as given: drives the result into clipping
        send_rotation(32'h7fffffff, 32'h80000000, 32'h7fffffff, 18'sh1ffff, 18'sh1ffff,
                      18'sh1ffff, 26'sd11796480);
        send_rotation(32'h40000000, 32'sd0, 32'sd0, 18'sh20000, 18'sh20000, 18'sh20000,
                      26'sh2000000);
        send_rotation(32'sd1, -32'sd1, 32'sd1, 18'sd37837, 18'sd37837, 18'sd37837,
                      26'sd7864320);
        send_rotation(32'hffffffff, 32'h12345678, 32'hedcba987, 18'sd0, -UNIT, 18'sd0,
                      26'sd17694721);
    endtask

    task automatic test_random(input int count);
        logic signed [17:0] ax, ay, az;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(2) == 0) begin
                {ax, ay, az} = '0;
                case ($urandom_range(2))
                    0: ax = $urandom_range(1) ? UNIT : -UNIT;
                    1: ay = $urandom_range(1) ? UNIT : -UNIT;
                    default: az = $urandom_range(1) ? UNIT : -UNIT;
                endcase
            end else begin
                ax = random_axis();
                ay = random_axis();
                az = random_axis();
            end
            send_rotation(random_component(), random_component(), random_component(),
                          ax, ay, az, random_angle());
        end
    endtask

    // Back-to-back traffic with no gaps on either side
    task automatic test_burst(input int count);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(count);
        send_idle_pct = 38;
        recv_idle_pct = 38;
    endtask

    // Sender holds off until the pipeline has fully drained, then resumes
    task automatic test_drain_pause();
        test_random(20);
        s_axis_tvalid <= 1'b0;
        while (expected_rotations.size() != 0) @(posedge i_clk);
        test_random(30);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(200);
        test_burst(120);
        test_drain_pause();
        test_random(150);
        s_axis_tvalid <= 1'b0;
        while (expected_rotations.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule

>>> axis_angle_vector_rotate.f
+incdir+rtl/core
rtl/core/aavr_pkg.sv
rtl/core/aavr_cordic.sv
rtl/core/axis_angle_vector_rotate.sv
bench/testbench.sv
